>>> rtl/rbst_pkg.sv
// ----------------------------------------------------------------------------
// rbst_pkg: shared types and constants for the ray/box slab test
// Fixed widths of the distance datapath and the per-axis slab type.
// ----------------------------------------------------------------------------
package rbst_pkg;

  // number of spatial axes
  localparam int unsigned NumAxes = 3;

  // coordinate and distance width
  localparam int unsigned CoordW  = 32;
  // plane minus origin, exact
  localparam int unsigned DiffW   = CoordW + 1;
  // difference times reciprocal direction, exact
  localparam int unsigned ProdW   = DiffW + CoordW;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [ProdW-1:0]  prod_t;

  // entry/exit distance pair of one slab
  typedef struct packed {
    coord_t t_near;
    coord_t t_far;
  } slab_t;

endpackage

>>> rtl/ray_box_slab_test.sv
// ----------------------------------------------------------------------------
// ray_box_slab_test: pipelined ray against axis-aligned box slab test
// Five register stages: plane select and difference, multiply, shift and
// saturate, y slab merge, z slab merge with the final interval check.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one test per transaction:
//   box corners, ray origin and per-axis reciprocal direction, all signed
//   fixed point with FRAC_BITS fraction bits.
//   Output channel (out_valid_o / out_ready_i) returns one result per test:
//   hit_o, and the entry/exit distances t_enter_o / t_exit_o (zero on a miss).
//   Throughput: one test per cycle while out_ready_i is high; the six 33x32
//   multipliers of the multiply stage are the only deep path and each stage
//   carries one item.
//   Each stage has its own valid bit and advances when it is empty or when
//   the stage after it advances, so bubbles collapse and a stalled receiver
//   only holds the items that are blocked behind the output register.
//   in_ready_o is high whenever any pipeline slot ahead is free.
//   Reset clears all valid bits; no result is presented until a new test
//   is accepted. Results come out in input order.
// ----------------------------------------------------------------------------
module ray_box_slab_test #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] box_min_x_i,
  input  logic [31:0] box_min_y_i,
  input  logic [31:0] box_min_z_i,
  input  logic [31:0] box_max_x_i,
  input  logic [31:0] box_max_y_i,
  input  logic [31:0] box_max_z_i,
  input  logic [31:0] origin_x_i,
  input  logic [31:0] origin_y_i,
  input  logic [31:0] origin_z_i,
  input  logic [31:0] inv_dir_x_i,
  input  logic [31:0] inv_dir_y_i,
  input  logic [31:0] inv_dir_z_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        hit_o,
  output logic [31:0] t_enter_o,
  output logic [31:0] t_exit_o
);

  localparam int unsigned NumStages = 5;
  localparam int unsigned NA        = rbst_pkg::NumAxes;
  localparam int unsigned CW        = rbst_pkg::CoordW;
  localparam int unsigned PW        = rbst_pkg::ProdW;

  // floor shift then saturate to the signed coordinate range
  function automatic rbst_pkg::coord_t sat_dist(input rbst_pkg::prod_t p);
    rbst_pkg::prod_t      s;
    logic [PW-CW:0]       hi;
    rbst_pkg::coord_t     r;
    s  = p >>> FRAC_BITS;
    hi = s[PW-1:CW-1];
    if ((&hi) || !(|hi)) begin
      r = s[CW-1:0];
    end else if (s[PW-1]) begin
      r = {1'b1, {(CW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CW-1){1'b1}}};
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // flow control: per-stage valid and advance
  // --------------------------------------------------------------------------
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] adv;

  always_comb begin
    adv[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign in_ready_o = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // input gather per axis
  // --------------------------------------------------------------------------
  rbst_pkg::coord_t lo_in  [NA];
  rbst_pkg::coord_t hi_in  [NA];
  rbst_pkg::coord_t org_in [NA];
  rbst_pkg::coord_t inv_in [NA];

  assign lo_in[0]  = box_min_x_i;
  assign lo_in[1]  = box_min_y_i;
  assign lo_in[2]  = box_min_z_i;
  assign hi_in[0]  = box_max_x_i;
  assign hi_in[1]  = box_max_y_i;
  assign hi_in[2]  = box_max_z_i;
  assign org_in[0] = origin_x_i;
  assign org_in[1] = origin_y_i;
  assign org_in[2] = origin_z_i;
  assign inv_in[0] = inv_dir_x_i;
  assign inv_in[1] = inv_dir_y_i;
  assign inv_in[2] = inv_dir_z_i;

  // --------------------------------------------------------------------------
  // stage 1: pick near/far plane by direction sign, subtract origin
  // --------------------------------------------------------------------------
  rbst_pkg::diff_t  dn_d [NA];
  rbst_pkg::diff_t  df_d [NA];
  rbst_pkg::diff_t  dn_q [NA];
  rbst_pkg::diff_t  df_q [NA];
  rbst_pkg::coord_t inv_q [NA];

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      if (inv_in[a][CW-1]) begin
        dn_d[a] = {hi_in[a][CW-1], hi_in[a]} - {org_in[a][CW-1], org_in[a]};
        df_d[a] = {lo_in[a][CW-1], lo_in[a]} - {org_in[a][CW-1], org_in[a]};
      end else begin
        dn_d[a] = {lo_in[a][CW-1], lo_in[a]} - {org_in[a][CW-1], org_in[a]};
        df_d[a] = {hi_in[a][CW-1], hi_in[a]} - {org_in[a][CW-1], org_in[a]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0] && in_valid_i) begin
      for (int a = 0; a < NA; a++) begin
        dn_q[a]  <= dn_d[a];
        df_q[a]  <= df_d[a];
        inv_q[a] <= inv_in[a];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: exact products
  // --------------------------------------------------------------------------
  rbst_pkg::prod_t pn_q [NA];
  rbst_pkg::prod_t pf_q [NA];

  always_ff @(posedge clk_i) begin
    if (adv[1] && vld_q[0]) begin
      for (int a = 0; a < NA; a++) begin
        pn_q[a] <= dn_q[a] * inv_q[a];
        pf_q[a] <= df_q[a] * inv_q[a];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: scale back to fixed point and saturate
  // --------------------------------------------------------------------------
  rbst_pkg::slab_t slab_q [NA];

  always_ff @(posedge clk_i) begin
    if (adv[2] && vld_q[1]) begin
      for (int a = 0; a < NA; a++) begin
        slab_q[a].t_near <= sat_dist(pn_q[a]);
        slab_q[a].t_far  <= sat_dist(pf_q[a]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: overlap check and narrowing with the y slab
  // --------------------------------------------------------------------------
  rbst_pkg::slab_t ivl_d, ivl_q;
  rbst_pkg::slab_t slab_z_q;
  logic            live_d, live_q;

  always_comb begin
    ivl_d  = slab_q[0];
    live_d = 1'b1;
    if (slab_q[0].t_near > slab_q[1].t_far || slab_q[1].t_near > slab_q[0].t_far) begin
      live_d = 1'b0;
    end else begin
      if (slab_q[1].t_near > slab_q[0].t_near) ivl_d.t_near = slab_q[1].t_near;
      if (slab_q[1].t_far < slab_q[0].t_far)   ivl_d.t_far  = slab_q[1].t_far;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[3] && vld_q[2]) begin
      ivl_q    <= ivl_d;
      live_q   <= live_d;
      slab_z_q <= slab_q[2];
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: z slab, final interval check, zero on miss
  // --------------------------------------------------------------------------
  rbst_pkg::slab_t fin;
  logic            hit_d, hit_q;
  rbst_pkg::coord_t t_enter_q, t_exit_q;

  always_comb begin
    fin   = ivl_q;
    hit_d = live_q;
    if (ivl_q.t_near > slab_z_q.t_far || slab_z_q.t_near > ivl_q.t_far) begin
      hit_d = 1'b0;
    end else begin
      if (slab_z_q.t_near > ivl_q.t_near) fin.t_near = slab_z_q.t_near;
      if (slab_z_q.t_far < ivl_q.t_far)   fin.t_far  = slab_z_q.t_far;
    end
    if (fin.t_near > fin.t_far) begin
      hit_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[4] && vld_q[3]) begin
      hit_q     <= hit_d;
      t_enter_q <= hit_d ? fin.t_near : '0;
      t_exit_q  <= hit_d ? fin.t_far  : '0;
    end
  end

  assign out_valid_o = vld_q[NumStages-1];
  assign hit_o       = hit_q;
  assign t_enter_o   = t_enter_q;
  assign t_exit_o    = t_exit_q;

`ifndef SYNTHESIS
  // a miss reports a zero interval
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (t_enter_o == '0 && t_exit_o == '0))
    else $error("miss with nonzero interval");

  // a hit reports an ordered interval
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hit_o) |-> ($signed(t_enter_o) <= $signed(t_exit_o)))
    else $error("hit with entry after exit");

  // an accepted transaction occupies the first stage next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0])
    else $error("accepted transaction lost at stage 1");

  // an empty output register never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with free pipeline");
`endif

endmodule
